// ===== design/hpt_pkg.sv =====
package hpt_pkg;

  // Fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int RND_W     = SUM_W - FRAC_BITS;

  // Divider: numerator magnitude is |t| << FRAC_BITS, padded to whole stages
  localparam int BITS_PER_STAGE = 2;
  localparam int NUM_W          = VAL_W + FRAC_BITS;
  localparam int DIV_STAGES     = (NUM_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int NUM_PAD        = DIV_STAGES * BITS_PER_STAGE;

  // Stream packing
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 96;

  // Operation codes carried in in_tuser
  typedef enum logic {
    OP_LOAD      = 1'b0,
    OP_TRANSFORM = 1'b1
  } op_t;

  typedef struct packed {
    logic [VAL_W-1:0]   rem;
    logic [NUM_PAD-1:0] num;
  } div_lane_t;

  // BITS_PER_STAGE restoring-division steps: numerator bits shift out at the top,
  // quotient bits shift in at the bottom.
  function automatic div_lane_t div_step(div_lane_t lane, logic [VAL_W-1:0] den);
    div_lane_t        res;
    logic [VAL_W:0]   part;
    res = lane;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      part    = {res.rem, res.num[NUM_PAD-1]};
      res.num = {res.num[NUM_PAD-2:0], 1'b0};
      if (part >= {1'b0, den}) begin
        part       = part - {1'b0, den};
        res.num[0] = 1'b1;
      end
      res.rem = part[VAL_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== design/homogeneous_point_transform_core.sv =====
// Channel | handshake              | tdata, low bit up                      | tuser
// in      | in_tvalid, in_tready   | coef_index, coef_value, point_x/y/z    | op
// out     | out_tvalid, out_tready | out_x, out_y, out_z                    | w_was_zero, saturated
//
// One transaction per cycle in while the output is not stalled; a transform result passes through
// multiply, sum, round/clamp, divide set-up, DIV_STAGES divider stages and the output register.
// The divider retires two quotient bits per stage; it sets the latency.
// Loads update the matrix at once and give no result.
// Reset clears the matrix and all valid bits. A stall at the output freezes every stage.
module homogeneous_point_transform_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // coef_index[3:0], coef_value[35:4], point_x[67:36], point_y[99:68], point_z[131:100]
  input  logic [hpt_pkg::IN_DATA_W-1:0]       in_tdata,
  // op
  input  logic [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [hpt_pkg::OUT_DATA_W-1:0]      out_tdata,
  // w_was_zero[0], saturated[1]
  output logic [1:0]                          out_tuser
);

  localparam int W  = hpt_pkg::VAL_W;
  localparam int F  = hpt_pkg::FRAC_BITS;
  localparam int DS = hpt_pkg::DIV_STAGES;
  localparam int NP = hpt_pkg::NUM_PAD;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Input unpacking
  logic               acc;
  logic [3:0]         coef_index;
  logic signed [W-1:0] coef_value;
  logic signed [W-1:0] pt [3];
  assign acc        = in_tvalid && in_tready;
  assign coef_index = in_tdata[3:0];
  assign coef_value = in_tdata[35:4];
  assign pt[0]      = in_tdata[67:36];
  assign pt[1]      = in_tdata[99:68];
  assign pt[2]      = in_tdata[131:100];

  // Matrix store
  logic signed [W-1:0] mat_r [16];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) mat_r[i] <= '0;
    end else if (acc && in_tuser[0] == hpt_pkg::OP_LOAD) begin
      mat_r[coef_index] <= coef_value;
    end
  end

  // Stage 1: twelve products, translation column carried along
  logic                       s1_v_r;
  logic signed [hpt_pkg::PROD_W-1:0] s1_p_r [4][3];
  logic signed [W-1:0]        s1_c_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= acc && in_tuser[0] == hpt_pkg::OP_TRANSFORM;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) s1_p_r[r][c] <= mat_r[r*4+c] * pt[c];
        s1_c_r[r] <= mat_r[r*4+3];
      end
    end
  end

  // Stage 2: row sums with rounding bias
  logic                              s2_v_r;
  logic signed [hpt_pkg::SUM_W-1:0]  s2_s_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        s2_s_r[r] <= hpt_pkg::SUM_W'(s1_p_r[r][0]) + hpt_pkg::SUM_W'(s1_p_r[r][1])
                   + hpt_pkg::SUM_W'(s1_p_r[r][2])
                   + (hpt_pkg::SUM_W'(s1_c_r[r]) <<< F)
                   + (hpt_pkg::SUM_W'(1) << (F - 1));
      end
    end
  end

  // Stage 3: drop fraction bits and clamp to 32 bits
  logic                      s3_v_r;
  logic signed [W-1:0]       s3_t_r [4];
  logic                      s3_sat_r;
  logic signed [hpt_pkg::RND_W-1:0] rnd [4];
  logic signed [W-1:0]       clp [4];
  logic [3:0]                clp_sat;
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      rnd[r] = hpt_pkg::RND_W'(s2_s_r[r] >>> F);
      if (rnd[r] > hpt_pkg::RND_W'(32'sh7fffffff)) begin
        clp[r] = 32'sh7fffffff; clp_sat[r] = 1'b1;
      end else if (rnd[r] < -(hpt_pkg::RND_W'(33'sh080000000))) begin
        clp[r] = 32'sh80000000; clp_sat[r] = 1'b1;
      end else begin
        clp[r] = rnd[r][W-1:0]; clp_sat[r] = 1'b0;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (en) s3_v_r <= s2_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) s3_t_r[r] <= clp[r];
      s3_sat_r <= |clp_sat;
    end
  end

  // Divider pipeline: index 0 is the set-up stage, index k after k divider stages
  logic                    d_v_r   [DS+1];
  hpt_pkg::div_lane_t      d_lane_r[DS+1][3];
  logic [W-1:0]            d_den_r [DS+1];
  logic [2:0]              d_neg_r [DS+1];
  logic signed [W-1:0]     d_t_r   [DS+1][3];
  logic                    d_wz_r  [DS+1];
  logic                    d_sat_r [DS+1];

  logic [W-1:0] mag_w;
  assign mag_w = s3_t_r[3][W-1] ? W'(-s3_t_r[3]) : W'(s3_t_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DS; k++) d_v_r[k] <= 1'b0;
    end else if (en) begin
      d_v_r[0] <= s3_v_r;
      for (int k = 1; k <= DS; k++) d_v_r[k] <= d_v_r[k-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_den_r[0] <= mag_w;
      d_wz_r[0]  <= s3_t_r[3] == '0;
      d_sat_r[0] <= s3_sat_r;
      for (int c = 0; c < 3; c++) begin
        d_lane_r[0][c].rem <= '0;
        d_lane_r[0][c].num <= NP'(s3_t_r[c][W-1] ? W'(-s3_t_r[c]) : W'(s3_t_r[c])) << F;
        d_neg_r[0][c]      <= s3_t_r[c][W-1] ^ s3_t_r[3][W-1];
        d_t_r[0][c]        <= s3_t_r[c];
      end
      for (int k = 1; k <= DS; k++) begin
        d_den_r[k] <= d_den_r[k-1];
        d_wz_r[k]  <= d_wz_r[k-1];
        d_sat_r[k] <= d_sat_r[k-1];
        d_neg_r[k] <= d_neg_r[k-1];
        for (int c = 0; c < 3; c++) begin
          d_lane_r[k][c] <= hpt_pkg::div_step(d_lane_r[k-1][c], d_den_r[k-1]);
          d_t_r[k][c]    <= d_t_r[k-1][c];
        end
      end
    end
  end

  // Output stage: sign, clamp, select undivided values on zero w
  logic [W-1:0] q_val [3];
  logic [2:0]   q_sat;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (d_neg_r[DS][c]) begin
        if (d_lane_r[DS][c].num > NP'(33'h080000000)) begin
          q_val[c] = 32'h80000000; q_sat[c] = 1'b1;
        end else begin
          q_val[c] = W'(-d_lane_r[DS][c].num); q_sat[c] = 1'b0;
        end
      end else begin
        if (d_lane_r[DS][c].num > NP'(32'h7fffffff)) begin
          q_val[c] = 32'h7fffffff; q_sat[c] = 1'b1;
        end else begin
          q_val[c] = d_lane_r[DS][c].num[W-1:0]; q_sat[c] = 1'b0;
        end
      end
    end
  end

  logic                  out_v_r;
  logic [hpt_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [1:0]            out_user_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= d_v_r[DS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (d_wz_r[DS]) begin
        out_data_r <= {d_t_r[DS][2], d_t_r[DS][1], d_t_r[DS][0]};
        out_user_r <= {d_sat_r[DS], 1'b1};
      end else begin
        out_data_r <= {q_val[2], q_val[1], q_val[0]};
        out_user_r <= {d_sat_r[DS] | (|q_sat), 1'b0};
      end
    end
  end
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Checks
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tuser[0] == hpt_pkg::OP_LOAD |=> !s1_v_r)
    else $error("load transaction entered the pipeline");
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s1_v_r) && $stable(s3_v_r) && $stable(d_v_r[DS]))
    else $error("pipeline moved during stall");
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !s1_v_r && !d_v_r[0])
    else $error("valid bits not cleared by reset");
  a_wz_no_div_sat: assert property (@(posedge clk) disable iff (!rst_n)
    en && d_v_r[DS] && d_wz_r[DS] && !d_sat_r[DS] |=> !out_tuser[1])
    else $error("saturation raised on undivided result");

endmodule
